/* rtl/drt_pkg.sv */
`default_nettype none
package drt_pkg;

   // Input segment header as it arrives on the request channel.
   typedef struct packed {
      logic        is_tagged;
      logic        is_last;
      logic [15:0] llp_length;
      logic [31:0] sink_tag;
      logic [31:0] queue_number;
      logic [31:0] msg_seq;
      logic [7:0]  ulp_control;
      logic [31:0] ulp_payload;
      logic [7:0]  reserved_ulp;
   } req_type;

   typedef enum logic [1:0] {
      STATUS_ACCUMULATED = 2'd0,
      STATUS_COMPLETE    = 2'd1,
      STATUS_FULL        = 2'd2,
      STATUS_SHORT       = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        out_tagged;
      logic [31:0] out_tag;
      logic [31:0] out_queue;
      logic [31:0] out_seq;
      logic [31:0] total_length;
      logic [7:0]  out_ulp_control;
      logic [31:0] out_ulp_payload;
      logic [7:0]  out_reserved_ulp;
      logic [31:0] receive_seq_now;
   } rsp_type;

   // Classified segment handed from the front end to the table engine.
   typedef struct packed {
      logic        is_tagged;
      logic        is_last;
      logic        is_short;
      logic [15:0] len;
      logic [63:0] key;
      logic [7:0]  ulp_control;
      logic [31:0] ulp_payload;
      logic [7:0]  reserved_ulp;
   } seg_type;

   typedef enum logic {
      REG_TAGGED_HDR   = 1'b0,
      REG_UNTAGGED_HDR = 1'b1
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [7:0]  TAGGED_HDR_RESET   = 8'd14;
   localparam logic [7:0]  UNTAGGED_HDR_RESET = 8'd18;
   localparam logic [7:0]  HDR_ADJUST         = 8'd2;
   localparam logic [31:0] RECEIVE_SEQ_RESET  = 32'd1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

/* rtl/drt_front.sv */
`default_nettype none
module drt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire drt_pkg::req_type              req_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [drt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               seg_valid,
   input  wire logic                          seg_ready,
   output drt_pkg::seg_type                   seg_data
);
   import drt_pkg::*;

   logic [7:0]    tagged_hdr_ff, tagged_hdr_in;
   logic [7:0]    untagged_hdr_ff, untagged_hdr_in;
   reg_index_type reg_sel;
   logic          reg_write;
   logic [7:0]    hdr;
   logic [7:0]    overhead;

   assign reg_sel   = reg_index_type'(paddr[2]);
   assign reg_write = psel && penable && pwrite;

   always_comb begin
      tagged_hdr_in   = tagged_hdr_ff;
      untagged_hdr_in = untagged_hdr_ff;
      prdata          = '0;
      unique case (reg_sel)
         REG_TAGGED_HDR: begin
            prdata = {24'd0, tagged_hdr_ff};
            if (reg_write) tagged_hdr_in = pwdata[7:0];
         end
         REG_UNTAGGED_HDR: begin
            prdata = {24'd0, untagged_hdr_ff};
            if (reg_write) untagged_hdr_in = pwdata[7:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagged_hdr_ff   <= TAGGED_HDR_RESET;
         untagged_hdr_ff <= UNTAGGED_HDR_RESET;
      end else begin
         tagged_hdr_ff   <= tagged_hdr_in;
         untagged_hdr_ff <= untagged_hdr_in;
      end
   end

   // Classify: overhead clamps at zero, short length flagged (its length field then wraps).
   always_comb begin
      hdr      = req_data.is_tagged ? tagged_hdr_ff : untagged_hdr_ff;
      overhead = (hdr >= HDR_ADJUST) ? (hdr - HDR_ADJUST) : '0;
      seg_data.is_tagged    = req_data.is_tagged;
      seg_data.is_last      = req_data.is_last;
      seg_data.is_short     = req_data.llp_length < {8'd0, overhead};
      seg_data.len          = req_data.llp_length - {8'd0, overhead};
      seg_data.key          = req_data.is_tagged ? {32'd0, req_data.sink_tag}
                                                 : {req_data.queue_number, req_data.msg_seq};
      seg_data.ulp_control  = req_data.ulp_control;
      seg_data.ulp_payload  = req_data.ulp_payload;
      seg_data.reserved_ulp = req_data.reserved_ulp;
   end

   assign seg_valid = req_valid;
   assign req_ready = seg_ready;

endmodule
`default_nettype wire

/* rtl/drt_queue.sv */
`default_nettype none
module drt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire drt_pkg::seg_type wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output drt_pkg::seg_type      rd_data
);
   import drt_pkg::*;

   seg_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign wr_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

/* rtl/drt_back.sv */
`default_nettype none
module drt_back #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             seg_valid,
   output logic                  seg_ready,
   input  wire drt_pkg::seg_type seg_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output drt_pkg::rsp_type      rsp_data
);
   import drt_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic {
      ST_LOOK,
      ST_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        receive_seq_ff, receive_seq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Table cells: each entry compared in place against the lookup key.
   logic               etag_ff [ENTRIES];
   logic [63:0]        ekey_ff [ENTRIES];
   logic [31:0]        elen_ff [ENTRIES];

   seg_type            item_ff;
   logic [ENTRIES-1:0] match_ff, match_in;
   logic               hit_any_ff, hit_any_in;
   logic [31:0]        hit_len_ff, hit_len_in;
   logic               free_any_ff, free_any_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   logic               look;
   logic               do_update;
   logic               alloc;
   logic [ENTRIES-1:0] alloc_vec;
   logic [ENTRIES-1:0] len_wr_vec;
   logic [31:0]        len32;
   logic [31:0]        sum_len;

   assign seg_ready = state_ff == ST_LOOK;
   assign look      = seg_valid && seg_ready;
   assign do_update = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lookup cycle: match vector, matched length and lowest free entry.
   always_comb begin
      match_in    = '0;
      hit_len_in  = '0;
      free_idx_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (etag_ff[i] == seg_data.is_tagged)
                       && (ekey_ff[i] == seg_data.key);
         hit_len_in  = hit_len_in | (match_in[i] ? elen_ff[i] : 32'd0);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx_in = IDX_W'(i);
      end
      hit_any_in  = |match_in;
      free_any_in = ~&valid_ff;
   end

   // Update cycle.
   always_comb begin
      len32   = {16'd0, item_ff.len};
      sum_len = hit_len_ff + len32;
      alloc   = do_update && !item_ff.is_short && !hit_any_ff && !item_ff.is_last
                && free_any_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         alloc_vec[i]  = alloc && (free_idx_ff == IDX_W'(i));
         len_wr_vec[i] = alloc_vec[i] || (do_update && !item_ff.is_short
                         && !item_ff.is_last && match_ff[i]);
      end

      valid_in       = valid_ff | alloc_vec;
      receive_seq_in = receive_seq_ff;
      rsp_data_in    = '0;
      rsp_data_in.status = STATUS_ACCUMULATED;

      if (item_ff.is_short) begin
         rsp_data_in.status = STATUS_SHORT;
      end else if (item_ff.is_last) begin
         rsp_data_in.status       = STATUS_COMPLETE;
         rsp_data_in.out_tagged   = item_ff.is_tagged;
         rsp_data_in.total_length = hit_any_ff ? sum_len : len32;
         if (do_update && hit_any_ff) valid_in = valid_ff & ~match_ff;
         if (item_ff.is_tagged) begin
            rsp_data_in.out_tag          = item_ff.key[31:0];
            rsp_data_in.out_reserved_ulp = item_ff.reserved_ulp;
         end else begin
            rsp_data_in.out_queue       = item_ff.key[63:32];
            rsp_data_in.out_seq         = item_ff.key[31:0];
            rsp_data_in.out_ulp_control = item_ff.ulp_control;
            rsp_data_in.out_ulp_payload = item_ff.ulp_payload;
            if (do_update) receive_seq_in = receive_seq_ff + 32'd1;
         end
      end else if (!hit_any_ff && !free_any_ff) begin
         rsp_data_in.status = STATUS_FULL;
      end
      rsp_data_in.receive_seq_now = receive_seq_in;

      rsp_valid_in = do_update ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      state_in = state_ff;
      unique case (state_ff)
         ST_LOOK:   if (look) state_in = ST_UPDATE;
         ST_UPDATE: if (do_update) state_in = ST_LOOK;
         default:   state_in = ST_LOOK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOOK;
         valid_ff       <= '0;
         receive_seq_ff <= RECEIVE_SEQ_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         receive_seq_ff <= receive_seq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (look) begin
         item_ff     <= seg_data;
         match_ff    <= match_in;
         hit_any_ff  <= hit_any_in;
         hit_len_ff  <= hit_len_in;
         free_any_ff <= free_any_in;
         free_idx_ff <= free_idx_in;
      end
      if (do_update) rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < ENTRIES; i++) begin
         if (alloc_vec[i]) begin
            etag_ff[i] <= item_ff.is_tagged;
            ekey_ff[i] <= item_ff.key;
         end
         if (len_wr_vec[i]) elen_ff[i] <= alloc_vec[i] ? len32 : sum_len;
      end
   end

endmodule
`default_nettype wire

/* rtl/ddp_segment_reassembly_tracker_top.sv */
// A result becomes valid once its request has passed the queue entry, the
//   lookup registers and the response register (lookup from the queue head,
//   then the table update). The table engine takes no new segment until its
//   lookup/update pair is through; the two-entry queue takes requests until full.
// Reset: synchronous, active high; clears every table entry at once, sets the
//   receive sequence to 1 and the header registers to 14 and 18. No clearing pass.
`default_nettype none
module ddp_segment_reassembly_tracker_top #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire drt_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output drt_pkg::rsp_type                   rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [drt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import drt_pkg::*;

   // Front end -> queue, queue -> table engine.
   logic    fq_valid;
   logic    fq_ready;
   seg_type fq_data;
   logic    qb_valid;
   logic    qb_ready;
   seg_type qb_data;

   // Register port never stalls a transfer.
   assign pready = 1'b1;

   // Hold the header size registers, classify each segment (payload length,
   // short flag, lookup key).
   drt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .seg_valid (fq_valid),
      .seg_ready (fq_ready),
      .seg_data  (fq_data)
   );

   // Decouple intake from the table engine.
   drt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   // Look up the message table, accumulate or allocate, complete and free,
   // advance the receive sequence; drive the response register.
   drt_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (qb_valid),
      .seg_ready (qb_ready),
      .seg_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/drt_checker.sv */
`default_nettype none
module drt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire drt_pkg::rsp_type rsp_data,
   input wire logic             pready
);
   import drt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_completion_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_COMPLETE |->
         !rsp_data.out_tagged && rsp_data.out_tag == '0 && rsp_data.out_queue == '0
         && rsp_data.out_seq == '0 && rsp_data.total_length == '0
         && rsp_data.out_ulp_control == '0 && rsp_data.out_ulp_payload == '0
         && rsp_data.out_reserved_ulp == '0)
      else $error("completion fields set without a completion");

   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_COMPLETE |->
         (rsp_data.out_tagged && rsp_data.out_queue == '0 && rsp_data.out_seq == '0
          && rsp_data.out_ulp_control == '0 && rsp_data.out_ulp_payload == '0)
         || (!rsp_data.out_tagged && rsp_data.out_tag == '0
          && rsp_data.out_reserved_ulp == '0))
      else $error("completion carries fields of the other kind");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port stalled");

endmodule

bind ddp_segment_reassembly_tracker_top drt_checker u_drt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
`default_nettype wire

/* tb/tb_ddp_segment_reassembly_tracker_top.sv */
`default_nettype none
module tb_ddp_segment_reassembly_tracker_top;
   timeunit 1ns;
   timeprecision 1ps;
   import drt_pkg::*;

   localparam int unsigned SLOTS       = 16;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 300;

   // Clock, reset and every block input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Shadow of the tracker: header registers, message table, receive sequence.
   logic [7:0]  tagged_hdr   = TAGGED_HDR_RESET;
   logic [7:0]  untagged_hdr = UNTAGGED_HDR_RESET;
   logic        slot_busy   [SLOTS];
   logic        slot_tagged [SLOTS];
   logic [63:0] slot_key    [SLOTS];
   logic [31:0] slot_bytes  [SLOTS];
   logic [31:0] expected_rseq = RECEIVE_SEQ_RESET;

   // Outcomes predicted at each request transfer, oldest first.
   rsp_type segment_outcomes[$];

   // Headers of messages the random traffic believes are still open.
   req_type open_msgs[$];

   bit          idle_enabled   = 1'b1;
   int unsigned segments_sent  = 0;
   int unsigned outcomes_seen  = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   ddp_segment_reassembly_tracker_top #(.ENTRIES(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy[i]   = 1'b0;
         slot_tagged[i] = 1'b0;
         slot_key[i]    = '0;
         slot_bytes[i]  = '0;
      end
   end

   // Work out the outcome of one segment and update the shadow table.
   function automatic rsp_type track_segment(input req_type seg);
      rsp_type     r;
      logic [7:0]  hdr;
      logic [31:0] overhead;
      logic [31:0] len;
      logic [31:0] total;
      logic [63:0] key;
      int          hit;
      int          slot;
      r    = '0;
      hit  = -1;
      slot = -1;
      hdr  = seg.is_tagged ? tagged_hdr : untagged_hdr;
      overhead = (hdr >= HDR_ADJUST) ? 32'(hdr - HDR_ADJUST) : 32'd0;
      key = seg.is_tagged ? {32'd0, seg.sink_tag} : {seg.queue_number, seg.msg_seq};
      if (32'(seg.llp_length) < overhead) begin
         // Short segment: flag it and leave the table alone.
         r.status = STATUS_SHORT;
      end else begin
         len = 32'(seg.llp_length) - overhead;
         for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_busy[i] && slot_tagged[i] == seg.is_tagged &&
                slot_key[i] == key)
               hit = i;
         end
         r.status = STATUS_ACCUMULATED;
         if (hit >= 0) begin
            slot_bytes[hit] = slot_bytes[hit] + len;
         end else if (!seg.is_last) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot < 0 && !slot_busy[i])
                  slot = i;
            end
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_busy[slot]   = 1'b1;
               slot_tagged[slot] = seg.is_tagged;
               slot_key[slot]    = key;
               slot_bytes[slot]  = len;
            end
         end
         if (seg.is_last) begin
            total = len;
            if (hit >= 0) begin
               total = slot_bytes[hit];
               slot_busy[hit] = 1'b0;
            end
            r.status       = STATUS_COMPLETE;
            r.out_tagged   = seg.is_tagged;
            r.total_length = total;
            if (seg.is_tagged) begin
               r.out_tag          = seg.sink_tag;
               r.out_reserved_ulp = seg.reserved_ulp;
            end else begin
               r.out_queue       = seg.queue_number;
               r.out_seq         = seg.msg_seq;
               r.out_ulp_control = seg.ulp_control;
               r.out_ulp_payload = seg.ulp_payload;
               expected_rseq     = expected_rseq + 32'd1;
            end
         end
      end
      r.receive_seq_now = expected_rseq;
      return r;
   endfunction

   // Segment with random upper-layer fields and the given kind, flag, length and key.
   function automatic req_type build_segment(input logic seg_tagged, input logic last,
                                             input logic [15:0] llp,
                                             input logic [31:0] key_hi,
                                             input logic [31:0] key_lo);
      req_type seg;
      seg.is_tagged    = seg_tagged;
      seg.is_last      = last;
      seg.llp_length   = llp;
      seg.sink_tag     = seg_tagged ? key_lo : $urandom;
      seg.queue_number = seg_tagged ? $urandom : key_hi;
      seg.msg_seq      = seg_tagged ? $urandom : key_lo;
      seg.ulp_control  = 8'($urandom);
      seg.ulp_payload  = $urandom;
      seg.reserved_ulp = 8'($urandom);
      return seg;
   endfunction

   // Mostly lengths that clear the header, with a few huge and a few short ones.
   function automatic logic [15:0] pick_length(input logic seg_tagged);
      logic [7:0]  hdr;
      int unsigned oh;
      int unsigned roll;
      hdr  = seg_tagged ? tagged_hdr : untagged_hdr;
      oh   = (hdr >= HDR_ADJUST) ? hdr - HDR_ADJUST : 0;
      roll = $urandom_range(99);
      if (roll < 5)
         return 16'($urandom_range(65535));
      if (roll < 10 && oh > 0)
         return 16'($urandom_range(oh - 1));
      return 16'(oh + $urandom_range(1500));
   endfunction

   // Present one segment, hold it until the transfer, then log its outcome.
   task automatic send_segment(input req_type seg);
      while (idle_enabled && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= seg;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      segment_outcomes.push_back(track_segment(seg));
      segments_sent++;
   endtask

   // Drop valid and hold off until every outcome has come back.
   task automatic settle_outcomes();
      req_valid <= 1'b0;
      while (segment_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_register(input reg_index_type idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_TAGGED_HDR)
         tagged_hdr = value;
      else
         untagged_hdr = value;
   endtask

   task automatic read_register(input reg_index_type idx, input logic [7:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      check_field(idx == REG_TAGGED_HDR ? "prdata tagged_header_bytes" :
                  "prdata untagged_header_bytes", {24'd0, want}, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Change both header sizes with the tracker idle, then read them back.
   task automatic set_headers(input logic [7:0] tagged_bytes, input logic [7:0] untagged_bytes);
      settle_outcomes();
      write_register(REG_TAGGED_HDR, tagged_bytes);
      write_register(REG_UNTAGGED_HDR, untagged_bytes);
      read_register(REG_TAGGED_HDR, tagged_bytes);
      read_register(REG_UNTAGGED_HDR, untagged_bytes);
   endtask

   // Reset values first, then a round trip through new values and back.
   task automatic test_register_access();
      read_register(REG_TAGGED_HDR, TAGGED_HDR_RESET);
      read_register(REG_UNTAGGED_HDR, UNTAGGED_HDR_RESET);
      set_headers(8'h5A, 8'hA5);
      set_headers(TAGGED_HDR_RESET, UNTAGGED_HDR_RESET);
   endtask

   // Field extremes, short, accumulated and complete statuses, and tagged/untagged keys that share bits.
   // Runs with the reset header sizes: tagged overhead 12, untagged 16.
   task automatic test_directed_segments();
      send_segment('0);                                   // short, everything zero
      send_segment('1);                                   // tagged single, all ones
      send_segment(build_segment(1'b0, 1'b1, 16'd16, 32'd0, 32'd0));   // zero payload
      send_segment(build_segment(1'b0, 1'b1, 16'd15, 32'd0, 32'd0));   // one byte short
      send_segment(build_segment(1'b1, 1'b0, 16'd11, 32'd0, 32'h55));  // one byte short
      send_segment(build_segment(1'b1, 1'b0, 16'd12, 32'd0, 32'h55));  // open tagged
      send_segment(build_segment(1'b0, 1'b0, 16'd100, 32'd0, 32'h55)); // open untagged
      // Same 64-bit key but other kind: must not hit the untagged entry.
      send_segment(build_segment(1'b1, 1'b1, 16'd1012, 32'd0, 32'h55));
      send_segment(build_segment(1'b0, 1'b0, 16'd216, 32'd0, 32'h55));
      // Short last segment must leave the open message untouched.
      send_segment(build_segment(1'b0, 1'b1, 16'd3, 32'd0, 32'h55));
      send_segment(build_segment(1'b0, 1'b1, 16'hFFFF, 32'd0, 32'h55));
      send_segment(build_segment(1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_segment(build_segment(1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_segment(build_segment(1'b1, 1'b0, 16'd12, 32'd0, 32'd0));
      send_segment(build_segment(1'b1, 1'b1, 16'd13, 32'd0, 32'd0));
      send_segment(build_segment(1'b0, 1'b1, 16'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_segment(build_segment(1'b1, 1'b1, 16'd500, 32'd0, 32'h8000_0001));
   endtask

   // Header sizes at and below the adjust, and the largest, on length edges.
   task automatic test_header_extremes();
      logic [7:0] sizes [5][2];
      sizes = '{'{8'd0, 8'd1}, '{8'd2, 8'd2}, '{8'd255, 8'd255},
                '{8'd1, 8'd255}, '{8'd255, 8'd0}};
      for (int s = 0; s < 5; s++) begin
         set_headers(sizes[s][0], sizes[s][1]);
         send_segment(build_segment(1'b1, 1'b1, 16'd0, 32'd0, 32'd9));
         send_segment(build_segment(1'b0, 1'b1, 16'd0, 32'd3, 32'd9));
         send_segment(build_segment(1'b1, 1'b1, 16'd252, 32'd0, 32'd9));
         send_segment(build_segment(1'b0, 1'b1, 16'd253, 32'd3, 32'd9));
         send_segment(build_segment(1'b1, 1'b0, 16'hFFFF, 32'd0, 32'd7));
         send_segment(build_segment(1'b1, 1'b1, 16'hFFFF, 32'd0, 32'd7));
      end
      set_headers(TAGGED_HDR_RESET, UNTAGGED_HDR_RESET);
   endtask

   // Fill every free slot, overflow it, hit and bypass it while full, then drain.
   task automatic test_table_full();
      req_type     held[$];
      req_type     seg;
      int unsigned free_slots;
      int unsigned pick;
      free_slots = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_busy[i])
            free_slots++;
      end
      for (int i = 0; i < free_slots; i++) begin
         seg = build_segment(1'($urandom), 1'b0, 16'd0, $urandom, $urandom);
         seg.llp_length = 16'(100 + $urandom_range(900));
         held.push_back(seg);
         send_segment(seg);
      end
      seg = build_segment(1'b0, 1'b0, 16'd500, $urandom, $urandom);
      send_segment(seg);                                  // no slot left
      seg = build_segment(1'b1, 1'b0, 16'd500, 32'd0, $urandom);
      send_segment(seg);                                  // no slot left, tagged
      seg = held[0];
      seg.llp_length = 16'd400;
      send_segment(seg);                                  // hit still accumulates
      seg = build_segment(1'b1, 1'b1, 16'd600, 32'd0, $urandom);
      send_segment(seg);                                  // single needs no slot
      while (held.size() != 0) begin
         pick = $urandom_range(held.size() - 1);
         seg = held[pick];
         held.delete(pick);
         seg.is_last    = 1'b1;
         seg.llp_length = 16'(200 + $urandom_range(300));
         seg.ulp_control  = 8'($urandom);
         seg.ulp_payload  = $urandom;
         seg.reserved_ulp = 8'($urandom);
         send_segment(seg);
      end
   endtask

   // One random segment: continue an open message, start one, or pure noise.
   task automatic send_random_segment();
      req_type     seg;
      int unsigned roll;
      int unsigned pick;
      logic        seg_tagged;
      roll = $urandom_range(99);
      if (roll < 55 && open_msgs.size() != 0) begin
         pick = $urandom_range(open_msgs.size() - 1);
         seg  = open_msgs[pick];
         seg.is_last      = ($urandom_range(99) < 30);
         seg.llp_length   = pick_length(seg.is_tagged);
         seg.ulp_control  = 8'($urandom);
         seg.ulp_payload  = $urandom;
         seg.reserved_ulp = 8'($urandom);
         if (seg.is_last)
            open_msgs.delete(pick);
      end else if (roll < 85) begin
         // Small key pools half the time so kinds and keys collide.
         seg_tagged = 1'($urandom);
         if ($urandom_range(1))
            seg = build_segment(seg_tagged, 1'b0, 16'd0, 32'($urandom_range(3)),
                                32'($urandom_range(7)));
         else
            seg = build_segment(seg_tagged, 1'b0, 16'd0, $urandom, $urandom);
         seg.is_last    = ($urandom_range(99) < 15);
         seg.llp_length = pick_length(seg_tagged);
         if (!seg.is_last && open_msgs.size() < SLOTS - 2)
            open_msgs.push_back(seg);
      end else begin
         seg = build_segment(1'($urandom), 1'($urandom), 16'($urandom), $urandom, $urandom);
      end
      send_segment(seg);
   endtask

   // Phases at several header settings; the first runs without any idling,
   // and each pauses halfway until all outcomes are in.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_enabled = 1'b0;
               set_headers(TAGGED_HDR_RESET, UNTAGGED_HDR_RESET);
            end
            1: begin
               idle_enabled = 1'b1;
               set_headers(8'($urandom_range(2, 40)), 8'($urandom_range(2, 40)));
            end
            2: set_headers(8'd255, 8'($urandom_range(2, 255)));
            default: set_headers(8'($urandom_range(1)), 8'd2);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
               settle_outcomes();
            send_random_segment();
         end
      end
      idle_enabled = 1'b1;
   endtask

   // Receiver: stall about one cycle in nine unless idling is off.
   always @(posedge clock) begin
      rsp_ready <= !idle_enabled || ($urandom_range(99) >= 11);
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin : check_outcome
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (segment_outcomes.size() == 0) begin
            $error("result transfer with no segment outstanding");
            mismatch_count++;
         end else begin
            want = segment_outcomes.pop_front();
            outcomes_seen++;
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("out_tagged", 32'(want.out_tagged), 32'(rsp_data.out_tagged));
            check_field("out_tag", want.out_tag, rsp_data.out_tag);
            check_field("out_queue", want.out_queue, rsp_data.out_queue);
            check_field("out_seq", want.out_seq, rsp_data.out_seq);
            check_field("total_length", want.total_length, rsp_data.total_length);
            check_field("out_ulp_control", 32'(want.out_ulp_control),
                        32'(rsp_data.out_ulp_control));
            check_field("out_ulp_payload", want.out_ulp_payload, rsp_data.out_ulp_payload);
            check_field("out_reserved_ulp", 32'(want.out_reserved_ulp),
                        32'(rsp_data.out_reserved_ulp));
            check_field("receive_seq_now", want.receive_seq_now, rsp_data.receive_seq_now);
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_ddp_segment_reassembly_tracker_top: errors");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed_segments();
      test_header_extremes();
      test_table_full();
      test_random_traffic();
      settle_outcomes();
      if (segment_outcomes.size() != 0) begin
         $error("%0d predicted outcomes never arrived", segment_outcomes.size());
         mismatch_count++;
      end
      repeat (10) @(posedge clock);
      $display("Covered %0d segment transfers and %0d result checks: header size edges,",
               segments_sent, outcomes_seen);
      $display("short and full-table cases, and interleaved random message traffic.");
      if (mismatch_count == 0)
         $display("tb_ddp_segment_reassembly_tracker_top: clean");
      else
         $display("tb_ddp_segment_reassembly_tracker_top: errors");
      $finish;
   end

endmodule
`default_nettype wire
